### hdl/vagd_pkg.sv
// Shared types, constants and coefficient tables for the VAG ADPCM block decoder.
`default_nettype none

package vagd_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int POS_W       = $clog2(BLOCK_BYTES);
	localparam int FRAC_BITS   = 14;

	localparam logic [POS_W-1:0] POS_HEADER     = POS_W'(0);
	localparam logic [POS_W-1:0] POS_FLAGS      = POS_W'(1);
	localparam logic [POS_W-1:0] POS_FIRST_DATA = POS_W'(2);
	localparam logic [POS_W-1:0] POS_LAST_DATA  = POS_W'(BLOCK_BYTES - 1);

	localparam logic [2:0] PRED_MAX = 3'd4;

	typedef logic [2:0] pred_idx_t;

	// One decode request to the sample unit.
	typedef struct packed {
		logic       fire;
		logic [3:0] nibble;
	} sample_req_t;

	function automatic pred_idx_t clamp_pred(input logic [3:0] nib);
		pred_idx_t r;
		if (nib > 4'(PRED_MAX)) begin
			r = PRED_MAX;
		end else begin
			r = nib[2:0];
		end
		return r;
	endfunction

	// Weight on the newest history sample, scaled by 2^14.
	function automatic logic signed [15:0] coef_newest(input pred_idx_t idx);
		logic signed [15:0] c;
		unique case (idx)
			3'd0: c = 16'sd0;
			3'd1: c = 16'sd15360;
			3'd2: c = 16'sd29440;
			3'd3: c = 16'sd25088;
			3'd4: c = 16'sd31232;
			default: c = 16'sd0;
		endcase
		return c;
	endfunction

	// Weight on the older history sample, scaled by 2^14.
	function automatic logic signed [15:0] coef_older(input pred_idx_t idx);
		logic signed [15:0] c;
		unique case (idx)
			3'd0: c = 16'sd0;
			3'd1: c = 16'sd0;
			3'd2: c = -16'sd13312;
			3'd3: c = -16'sd14080;
			3'd4: c = -16'sd15360;
			default: c = 16'sd0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### hdl/vagd_sample.sv
// Sample unit: prediction from the two-entry history, nibble scaling and 8-bit saturation.
`default_nettype none

module vagd_sample
	import vagd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sample_req_t        req,
	input  wire logic [3:0]         shift,
	input  wire pred_idx_t          pred_idx,
	input  wire pred_idx_t          pred_next,
	output logic signed [7:0]       pcm
);

	logic [31:0] newest_q;
	logic [31:0] older_q;
	// Older-tap product, registered ahead of its use so that only one multiply
	// sits in the sample recurrence.
	logic [31:0] term_q;

	logic [31:0] c0_ext;
	logic [31:0] c1_ext;
	logic [31:0] older_next;
	logic [31:0] prod_new;
	logic [31:0] pred_sum;
	logic signed [31:0] pred_val;
	logic signed [31:0] delta;
	logic signed [31:0] sample;

	assign c0_ext     = 32'(coef_newest(pred_idx));
	assign c1_ext     = 32'(coef_older(pred_next));
	assign older_next = req.fire ? newest_q : older_q;

	assign prod_new = newest_q * c0_ext;
	assign pred_sum = prod_new + term_q;
	assign pred_val = $signed(pred_sum) >>> FRAC_BITS;
	assign delta    = $signed({{16{req.nibble[3]}}, req.nibble, 12'h000}) >>> shift;
	assign sample   = delta + pred_val;

	always_comb begin
		if (sample > 32'sd32767) begin
			pcm = 8'sd127;
		end else if (sample < -32'sd32768) begin
			pcm = -8'sd128;
		end else begin
			pcm = sample[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			older_q  <= '0;
			term_q   <= '0;
		end else begin
			if (req.fire) begin
				newest_q <= sample;
				older_q  <= newest_q;
			end
			term_q <= older_next * c1_ext;
		end
	end

endmodule

`default_nettype wire

### hdl/vag_adpcm_block_decoder.sv
// Top level of the VAG ADPCM block decoder: byte intake, block sequencing and result register.
// The decoder takes 16-byte blocks one byte per request and returns 8-bit PCM samples one per
// request. Header and flags bytes produce nothing. Each data byte is decoded one nibble at a
// time, low nibble first, because the result channel carries one sample per cycle while the
// result side is free. Each accepted byte is held in the input register, and its two samples
// pass in order through the result register. The prediction history is cleared only by reset
// and carries across blocks and sounds.
`default_nettype none

module vag_adpcm_block_decoder
	import vagd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         stream_valid,
	output logic              stream_ready,
	input  wire logic [7:0]   stream_byte,
	output logic              sample_valid,
	input  wire logic         sample_ready,
	output logic signed [7:0] pcm_sample,
	output logic              sound_begins,
	output logic              sound_ends,
	output logic              last
);

	logic [7:0]       byte_s1;
	logic             valid_s1;
	logic [POS_W-1:0] pos_q;
	logic [3:0]       shift_q;
	pred_idx_t        pred_q;
	logic             begin_q;
	logic             end_q;
	logic             phase_q;

	logic             out_valid_q;
	logic signed [7:0] pcm_q;
	logic             begins_q;
	logic             ends_q;
	logic             last_q;

	logic             is_data;
	logic             out_free;
	logic             consume;
	pred_idx_t        pred_next;
	sample_req_t      req;
	logic signed [7:0] pcm_new;

	assign is_data  = (pos_q != POS_HEADER) && (pos_q != POS_FLAGS);
	assign out_free = !out_valid_q || sample_ready;
	assign req.fire = valid_s1 && is_data && out_free;
	assign req.nibble = phase_q ? byte_s1[7:4] : byte_s1[3:0];
	// A data byte leaves the input register once its high nibble is decoded.
	assign consume  = valid_s1 && (!is_data || (out_free && phase_q));
	assign stream_ready = !valid_s1 || consume;

	assign pred_next = (valid_s1 && pos_q == POS_HEADER) ? clamp_pred(byte_s1[7:4]) : pred_q;

	vagd_sample u_sample (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.shift     (shift_q),
		.pred_idx  (pred_q),
		.pred_next (pred_next),
		.pcm       (pcm_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= POS_HEADER;
			shift_q  <= '0;
			pred_q   <= '0;
			begin_q  <= 1'b0;
			end_q    <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (stream_valid && stream_ready) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			pred_q <= pred_next;
			if (valid_s1 && pos_q == POS_HEADER) begin
				shift_q <= byte_s1[3:0];
			end
			if (valid_s1 && pos_q == POS_FLAGS) begin
				begin_q <= byte_s1[2];
				end_q   <= byte_s1[0];
			end
			if (req.fire) begin
				phase_q <= !phase_q;
			end
			if (consume) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stream_valid && stream_ready) begin
			byte_s1 <= stream_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= req.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (req.fire) begin
			pcm_q    <= pcm_new;
			begins_q <= !phase_q && pos_q == POS_FIRST_DATA && begin_q;
			ends_q   <= phase_q && pos_q == POS_LAST_DATA && end_q;
			last_q   <= phase_q;
		end
	end

	assign sample_valid = out_valid_q;
	assign pcm_sample   = pcm_q;
	assign sound_begins = begins_q;
	assign sound_ends   = ends_q;
	assign last         = last_q;

	a_phase_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (valid_s1 && is_data))
		else $error("second nibble pending without a data byte");

	a_pred_range: assert property (@(posedge clk) disable iff (!arst_n)
		pred_q <= PRED_MAX)
		else $error("predictor index out of range");

	a_begin_first: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sound_begins) |-> !last)
		else $error("sound start flagged on a second sample");

	a_end_second: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sound_ends) |-> last)
		else $error("sound end flagged on a first sample");

	a_no_fire_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !sample_ready) |=> $stable(pcm_sample))
		else $error("held result overwritten");

endmodule

`default_nettype wire

### tb/sv/vag_adpcm_block_decoder_tb.sv
// Self-checking testbench for the VAG ADPCM block decoder, with its own sample predictor.
`default_nettype none

module vag_adpcm_block_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] POS_HEADER = 4'd0;
	localparam logic [3:0] POS_FLAGS  = 4'd1;
	localparam logic [3:0] POS_FIRST  = 4'd2;
	localparam logic [3:0] POS_LAST   = 4'd15;
	localparam logic [2:0] PRED_LIMIT = 3'd4;
	localparam int WEIGHT_SHIFT = 14;
	localparam int RANDOM_BLOCKS = 70;
	localparam int TAIL_BYTES = 120;
	localparam int HOLD_AFTER = 400;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 10;

	// Prediction weights on the newest and older history samples, scaled by 2^14.
	localparam int NEWEST_WEIGHT [5] = '{0, 15360, 29440, 25088, 31232};
	localparam int OLDER_WEIGHT [5] = '{0, 0, -13312, -14080, -15360};

	typedef struct packed {
		logic signed [7:0] pcm;
		logic              begins;
		logic              ends;
		logic              second;
	} pcm_out_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              stream_valid = 1'b0;
	logic              stream_ready;
	logic [7:0]        stream_byte = 8'h00;
	logic              sample_valid;
	logic              sample_ready = 1'b0;
	logic signed [7:0] pcm_sample;
	logic              sound_begins;
	logic              sound_ends;
	logic              last;

	logic [7:0] byte_backlog [$];
	pcm_out_t   pending_samples [$];
	pcm_out_t   seen_sample;
	pcm_out_t   want_sample;

	// Decoder state as the predictor tracks it.
	logic [3:0] blk_pos = 4'd0;
	logic [3:0] blk_shift = 4'd0;
	logic [2:0] blk_pred = 3'd0;
	logic       blk_begin = 1'b0;
	logic       blk_end = 1'b0;
	int         hist_new = 0;
	int         hist_old = 0;

	int  total_bytes = 0;
	int  bytes_in = 0;
	int  errors = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	int  hold_count = 0;
	bit  hold_done = 1'b0;
	int  stall_cycles = 0;
	logic [9:0] cyc = '0;

	vag_adpcm_block_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_valid (stream_valid),
		.stream_ready (stream_ready),
		.stream_byte  (stream_byte),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.pcm_sample   (pcm_sample),
		.sound_begins (sound_begins),
		.sound_ends   (sound_ends),
		.last         (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic decode_nibble(input logic [3:0] nib, output logic signed [7:0] pcm);
		int step;
		int pred;
		int smp;
		int top;
		step = int'({{16{nib[3]}}, nib, 12'h000});
		step = step >>> blk_shift;
		// Products and sum wrap at 32 bits, as the history does.
		pred = hist_new * NEWEST_WEIGHT[blk_pred] + hist_old * OLDER_WEIGHT[blk_pred];
		pred = pred >>> WEIGHT_SHIFT;
		smp = step + pred;
		hist_old = hist_new;
		hist_new = smp;
		top = smp >>> 8;
		if (top > 127) begin
			pcm = 8'sh7f;
		end else if (top < -128) begin
			pcm = 8'sh80;
		end else begin
			pcm = top[7:0];
		end
	endtask

	task automatic predict_byte(input logic [7:0] b);
		pcm_out_t   lo;
		pcm_out_t   hi;
		logic [3:0] pos;
		pos = blk_pos;
		blk_pos = blk_pos + 4'd1;
		if (pos == POS_HEADER) begin
			blk_shift = b[3:0];
			blk_pred = (b[7:4] > 4'(PRED_LIMIT)) ? PRED_LIMIT : b[6:4];
		end else if (pos == POS_FLAGS) begin
			blk_begin = b[2];
			blk_end = b[0];
		end else begin
			decode_nibble(b[3:0], lo.pcm);
			lo.begins = (pos == POS_FIRST) && blk_begin;
			lo.ends = 1'b0;
			lo.second = 1'b0;
			decode_nibble(b[7:4], hi.pcm);
			hi.begins = 1'b0;
			hi.ends = (pos == POS_LAST) && blk_end;
			hi.second = 1'b1;
			pending_samples.push_back(lo);
			pending_samples.push_back(hi);
		end
	endtask

	// Sender: pops the backlog, with random gaps between requests.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_valid <= 1'b0;
			stream_byte <= 8'h00;
			tx_gap <= 0;
		end else if (!stream_valid || stream_ready) begin
			if (tx_gap > 0) begin
				stream_valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (byte_backlog.size() > 0) begin
				stream_valid <= 1'b1;
				stream_byte <= byte_backlog.pop_front();
				if (!cyc[8] && byte_backlog.size() > TAIL_BYTES && $urandom_range(0, 5) == 0) begin
					tx_gap <= $urandom_range(1, 12);
				end
			end else begin
				stream_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off so the input backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ready <= 1'b0;
			rx_gap <= 0;
			hold_count <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && bytes_in >= HOLD_AFTER) begin
			sample_ready <= 1'b0;
			hold_count <= hold_count + 1;
			if (hold_count == HOLD_CYCLES - 1) begin
				hold_done <= 1'b1;
			end
		end else if (rx_gap > 0) begin
			sample_ready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else if (cyc[7] && bytes_in < total_bytes - TAIL_BYTES && $urandom_range(0, 7) == 0) begin
			sample_ready <= 1'b0;
			rx_gap <= $urandom_range(0, 11);
		end else begin
			sample_ready <= 1'b1;
		end
	end

	// Prediction on each accepted byte, and comparison of each accepted sample.
	always @(posedge clk) begin
		if (arst_n) begin
			cyc <= cyc + 10'd1;
			if (stream_valid && stream_ready) begin
				predict_byte(stream_byte);
				bytes_in <= bytes_in + 1;
			end
			if (sample_valid && sample_ready) begin
				seen_sample = '{pcm_sample, sound_begins, sound_ends, last};
				if (pending_samples.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected sample: pcm %0d begins %b ends %b last %b",
							pcm_sample, sound_begins, sound_ends, last);
					end
				end else begin
					want_sample = pending_samples.pop_front();
					if (seen_sample !== want_sample) begin
						errors++;
						if (errors <= 10) begin
							$display("sample mismatch: expected pcm %0d begins %b ends %b last %b, got pcm %0d begins %b ends %b last %b",
								want_sample.pcm, want_sample.begins, want_sample.ends,
								want_sample.second, pcm_sample, sound_begins, sound_ends, last);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((stream_valid && stream_ready) || (sample_valid && sample_ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] fill;
		bit         steady;
		int         p;
		// Header with an out-of-range predictor nibble, all flag bits set, data extremes.
		byte_backlog = '{8'hf0, 8'hff, 8'h00, 8'hff, 8'h77, 8'h88, 8'h7f, 8'hf7,
			8'h80, 8'h08, 8'h11, 8'hee, 8'h55, 8'haa, 8'h33, 8'hcc,
			8'h5f, 8'hfa, 8'h77, 8'h88, 8'h00, 8'hff, 8'h7f, 8'h80};
		// Finish the second block with random data.
		for (int i = 0; i < 8; i++) begin
			byte_backlog.push_back(8'($urandom));
		end
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			// Mostly valid predictors; a steady data pattern drives the history hard.
			if ($urandom_range(0, 4) == 0) begin
				p = $urandom_range(5, 15);
			end else begin
				p = $urandom_range(0, 4);
			end
			steady = ($urandom_range(0, 3) == 0);
			fill = 8'($urandom);
			if (steady) begin
				byte_backlog.push_back({4'(p), 4'($urandom_range(0, 2))});
			end else begin
				byte_backlog.push_back({4'(p), 4'($urandom)});
			end
			byte_backlog.push_back(8'($urandom));
			for (int i = 0; i < 14; i++) begin
				byte_backlog.push_back(steady ? fill : 8'($urandom));
			end
		end
		total_bytes = byte_backlog.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (bytes_in < total_bytes || pending_samples.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
